/* sv/brd_pkg.sv */
// shared types and constants for the byterun row decoder
// no dependencies
`timescale 1ns / 1ps

package brd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 2;
  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned CFG_DATA_W  = ROW_BYTES_W;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = ROW_BYTES_W'(40);

  // control byte codes
  localparam logic [BYTE_W-1:0] CTRL_NOP  = 8'd128;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

  typedef enum logic [0:0] {
    CFG_ROW_BYTES = 1'b0,
    CFG_COMP_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_RAW     = 1'b0,
    MODE_BYTERUN = 1'b1
  } comp_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_first;
    logic [BYTE_W-1:0]  byte_second;
    logic [COUNT_W-1:0] byte_count;
    logic               run_last;
    logic               row_end;
    logic               overrun_error;
  } brd_result_t;

endpackage

/* sv/brd_in_reg.sv */
// input register of the byterun row decoder: holds one compressed byte
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_in_reg
  import brd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              pop,
  output logic              held_valid,
  output logic [BYTE_W-1:0] held_byte
);

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;

  // free when empty or when the decoder takes the held byte this cycle
  assign in_ready   = !valid_r || pop;
  assign held_valid = valid_r;
  assign held_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

/* sv/brd_decode.sv */
// run-length decode step: control state, row position and repeat burst counter
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_decode
  import brd_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ROW_BYTES_W-1:0] row_bytes,
  input  comp_mode_t             comp_mode,
  input  logic                   held_valid,
  input  logic [BYTE_W-1:0]      held_byte,
  input  logic                   out_free,
  output logic                   pop,
  output logic                   res_valid,
  output brd_result_t            res
);

  localparam int unsigned POS_W  = (MAX_ROW_BYTES > 2) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned WIDE_W = (POS_W > ROW_BYTES_W) ? POS_W : ROW_BYTES_W;
  localparam int unsigned SUM_W  = WIDE_W + 1;
  localparam int unsigned CAP_I  = (MAX_ROW_BYTES > (2 ** ROW_BYTES_W) - 1) ?
                                   (2 ** ROW_BYTES_W) - 1 : MAX_ROW_BYTES;
  localparam logic [ROW_BYTES_W-1:0] LenCap = ROW_BYTES_W'(CAP_I);

  typedef struct packed {
    logic             closes;
    logic [POS_W-1:0] pos;
  } adv_t;

  // state
  logic              await_r, await_nxt;
  logic [BYTE_W-1:0] lit_r, lit_nxt;
  logic [BYTE_W-1:0] pend_r, pend_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              burst_r, burst_nxt;
  logic [BYTE_W-1:0] burst_rem_r, burst_rem_nxt;
  logic [BYTE_W-1:0] burst_val_r, burst_val_nxt;

  logic [ROW_BYTES_W-1:0] eff_len;
  logic [SUM_W-1:0]       len_ext;

  // one step of a repeat run
  logic [BYTE_W-1:0] run_rem, run_val, run_rem_after;
  logic              run_take2, run_rend;
  logic [POS_W-1:0]  run_pos;
  adv_t              adv1, adv2;

  logic [BYTE_W-1:0] lit_n, rep_n;
  logic              lit_over, rep_over;

  function automatic adv_t advance(input logic [POS_W-1:0] p,
                                   input logic [SUM_W-1:0] len);
    adv_t a;
    if (SUM_W'(p) + SUM_W'(1) >= len) begin
      a.closes = 1'b1;
      a.pos    = '0;
    end else begin
      a.closes = 1'b0;
      a.pos    = p + POS_W'(1);
    end
    return a;
  endfunction

  always_comb begin
    eff_len = (row_bytes > LenCap) ? LenCap : row_bytes;
    if (eff_len == '0) begin
      eff_len = ROW_BYTES_W'(1);
    end
  end
  assign len_ext = SUM_W'(eff_len);

  assign run_rem       = burst_r ? burst_rem_r : pend_r;
  assign run_val       = burst_r ? burst_val_r : held_byte;
  assign run_take2     = run_rem >= BYTE_W'(2);
  assign run_rem_after = run_rem - (run_take2 ? BYTE_W'(2) : BYTE_W'(1));
  assign adv1          = advance(pos_r, len_ext);
  assign adv2          = advance(adv1.pos, len_ext);
  assign run_pos       = run_take2 ? adv2.pos : adv1.pos;
  assign run_rend      = adv1.closes | (run_take2 & adv2.closes);

  assign lit_n    = held_byte + BYTE_W'(1);
  assign rep_n    = (held_byte ^ BYTE_MASK) + BYTE_W'(2);
  assign lit_over = (SUM_W'(pos_r) + SUM_W'(lit_n)) > len_ext;
  assign rep_over = (SUM_W'(pos_r) + SUM_W'(rep_n)) > len_ext;

  always_comb begin
    await_nxt     = await_r;
    lit_nxt       = lit_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    burst_nxt     = burst_r;
    burst_rem_nxt = burst_rem_r;
    burst_val_nxt = burst_val_r;
    pop           = 1'b0;
    res_valid     = 1'b0;
    res           = '0;

    if (burst_r) begin
      // repeat burst in flight, input waits
      if (out_free) begin
        res_valid         = 1'b1;
        res.byte_first    = run_val;
        res.byte_second   = run_take2 ? run_val : '0;
        res.byte_count    = run_take2 ? COUNT_TWO : COUNT_ONE;
        res.run_last      = run_rem_after == '0;
        res.row_end       = run_rend;
        pos_nxt           = run_pos;
        burst_nxt         = run_rem_after != '0;
        burst_rem_nxt     = run_rem_after;
      end
    end else if (held_valid && out_free) begin
      pop = 1'b1;
      if (comp_mode == MODE_RAW) begin
        await_nxt      = 1'b0;
        lit_nxt        = '0;
        pend_nxt       = '0;
        res_valid      = 1'b1;
        res.byte_first = held_byte;
        res.byte_count = COUNT_ONE;
        res.run_last   = 1'b1;
        res.row_end    = adv1.closes;
        pos_nxt        = adv1.pos;
      end else if (lit_r != '0) begin
        lit_nxt        = lit_r - BYTE_W'(1);
        res_valid      = 1'b1;
        res.byte_first = held_byte;
        res.byte_count = COUNT_ONE;
        res.run_last   = 1'b1;
        res.row_end    = adv1.closes;
        pos_nxt        = adv1.pos;
      end else if (await_r) begin
        await_nxt = 1'b0;
        pend_nxt  = '0;
        res_valid = 1'b1;
        if (pend_r == '0) begin
          // repeat run flagged as overrun at its control byte
          res.run_last      = 1'b1;
          res.overrun_error = 1'b1;
          pos_nxt           = '0;
        end else begin
          res.byte_first  = run_val;
          res.byte_second = run_take2 ? run_val : '0;
          res.byte_count  = run_take2 ? COUNT_TWO : COUNT_ONE;
          res.run_last    = run_rem_after == '0;
          res.row_end     = run_rend;
          pos_nxt         = run_pos;
          burst_nxt       = run_rem_after != '0;
          burst_rem_nxt   = run_rem_after;
          burst_val_nxt   = run_val;
        end
      end else if (held_byte < CTRL_NOP) begin
        if (lit_over) begin
          res_valid         = 1'b1;
          res.run_last      = 1'b1;
          res.overrun_error = 1'b1;
          pos_nxt           = '0;
        end else begin
          lit_nxt = lit_n;
        end
      end else if (held_byte != CTRL_NOP) begin
        await_nxt = 1'b1;
        pend_nxt  = rep_over ? '0 : rep_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      lit_r   <= '0;
      pend_r  <= '0;
      pos_r   <= '0;
      burst_r <= 1'b0;
    end else begin
      await_r <= await_nxt;
      lit_r   <= lit_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      burst_r <= burst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    burst_rem_r <= burst_rem_nxt;
    burst_val_r <= burst_val_nxt;
  end

`ifndef SYNTHESIS
  a_no_pop_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r |-> !pop)
    else $error("input byte taken during a repeat burst");

  a_burst_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r |-> burst_rem_r != '0)
    else $error("repeat burst active with nothing left");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.overrun_error) |->
      (res.byte_count == COUNT_NONE && res.run_last && !res.row_end))
    else $error("malformed overrun result");

  a_burst_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.run_last) |=> burst_r)
    else $error("run stopped before its last result");
`endif

endmodule

/* sv/brd_out_reg.sv */
// result register of the byterun row decoder, valid/ready toward the receiver
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_out_reg
  import brd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  brd_result_t res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_ready,
  output brd_result_t held
);

  logic        valid_r;
  brd_result_t data_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      data_r <= res;
    end
  end

endmodule

/* sv/byterun_row_decoder_core.sv */
// top level of the byterun (packbits) row decoder
// depends on brd_pkg, brd_in_reg, brd_decode, brd_out_reg
`timescale 1ns / 1ps

// usage
//   input channel in_valid/in_ready/in_byte carries one compressed byte per item
//   result channel out_valid/out_ready carries up to two decoded bytes per item,
//   with count, last-of-input, row-end and overrun flags
//   cfg_wr_en/cfg_index/cfg_wdata write row_bytes (index 0) or
//   compression_mode (index 1), only while the block is idle
// timing
//   an accepted byte is held in the input register, its first result is loaded
//   into the result register and shows on out_valid from there
//   with out_ready high, one input item per cycle while each byte gives at most
//   one result; a repeat run of n bytes gives ceil(n/2) results, one per cycle,
//   and the input register holds the next byte until the run is done
// reset
//   rst_n low at a clock edge empties both registers, clears the run state and
//   row position, and loads row_bytes 40 and run-length mode
// stall
//   while out_ready is low the result register holds; the input register still
//   takes one byte, then in_ready drops until the result drains

module byterun_row_decoder_core
  import brd_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // compressed bytes in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_byte,
  // decoded results out
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte_first,
  output logic [BYTE_W-1:0]     out_byte_second,
  output logic [COUNT_W-1:0]    out_byte_count,
  output logic                  out_run_last,
  output logic                  out_row_end,
  output logic                  out_overrun_error
);

  // configuration registers
  logic [ROW_BYTES_W-1:0] row_bytes_r;
  comp_mode_t             comp_mode_r;

  // between the stages
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              pop;
  logic              res_valid;
  brd_result_t       res;
  logic              out_free;
  brd_result_t       out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
      comp_mode_r <= MODE_BYTERUN;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_BYTES: row_bytes_r <= cfg_wdata[ROW_BYTES_W-1:0];
        CFG_COMP_MODE: comp_mode_r <= comp_mode_t'(cfg_wdata[0]);
      endcase
    end
  end

  // input register, refilled in the cycle its byte is taken
  brd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .pop        (pop),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // decode step: literal/repeat control, row tracking, repeat bursts
  brd_decode #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_bytes  (row_bytes_r),
    .comp_mode  (comp_mode_r),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .out_free   (out_free),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register toward the receiver
  brd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (out_res)
  );

  assign out_byte_first    = out_res.byte_first;
  assign out_byte_second   = out_res.byte_second;
  assign out_byte_count    = out_res.byte_count;
  assign out_run_last      = out_res.run_last;
  assign out_row_end       = out_res.row_end;
  assign out_overrun_error = out_res.overrun_error;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for byterun_row_decoder_core, the packbits row decoder
// depends on brd_pkg and the rtl of byterun_row_decoder_core
`timescale 1ns / 1ps

module tb_top;
  import brd_pkg::*;

  localparam int unsigned MAX_ROW_BYTES = 8192;
  // two register stages inside the block, so a few cycles cover any byte still in flight
  localparam int unsigned SETTLE_CYCLES = 8;
  // worst case: every item giving 64 results, each held off by the longest drawn stall
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned MAX_REPORTS   = 10;

  // one pending input item: the byte and whether to hold it back until all results drain
  typedef struct {
    logic [BYTE_W-1:0] value;
    bit                drain;
  } stream_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [0:0]            cfg_index = CFG_ROW_BYTES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte_first;
  logic [BYTE_W-1:0]     out_byte_second;
  logic [COUNT_W-1:0]    out_byte_count;
  logic                  out_run_last;
  logic                  out_row_end;
  logic                  out_overrun_error;

  byterun_row_decoder_core #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_first   (out_byte_first),
    .out_byte_second  (out_byte_second),
    .out_byte_count   (out_byte_count),
    .out_run_last     (out_run_last),
    .out_row_end      (out_row_end),
    .out_overrun_error(out_overrun_error)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bytes waiting to be sent, and decoded results still owed by the block
  stream_byte_t byte_stream[$];
  brd_result_t  decoded_queue[$];

  // shadow of the decoder: register copies plus run state
  logic [ROW_BYTES_W-1:0] row_bytes_q = ROW_BYTES_RST;
  comp_mode_t             mode_q = MODE_BYTERUN;
  bit                     awaiting_value = 1'b0;
  int unsigned            literal_left = 0;
  int unsigned            repeat_len = 0;
  int unsigned            row_pos = 0;

  // run statistics
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned overruns_seen = 0;
  int unsigned row_ends_seen = 0;
  int unsigned settings_used = 1;
  int unsigned failures = 0;

  // calm phases run with no idling on either side
  bit quiet = 1'b0;

  // driver bookkeeping
  bit          armed = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  // ---------------------------------------------------------------------------
  // decoder prediction
  // ---------------------------------------------------------------------------

  // row length in force: saturates at the maximum, zero behaves as one
  function automatic int unsigned row_limit();
    int unsigned n;
    n = row_bytes_q;
    if (n > MAX_ROW_BYTES) n = MAX_ROW_BYTES;
    if (n == 0) n = 1;
    return n;
  endfunction

  // count one decoded byte, report whether it closed the row
  function automatic bit close_byte();
    if (row_pos + 1 >= row_limit()) begin
      row_pos = 0;
      return 1'b1;
    end
    row_pos++;
    return 1'b0;
  endfunction

  function automatic void queue_result(logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] second,
                                       logic [COUNT_W-1:0] cnt, bit last, bit rend, bit err);
    brd_result_t r;
    r.byte_first    = first;
    r.byte_second   = second;
    r.byte_count    = cnt;
    r.run_last      = last;
    r.row_end       = rend;
    r.overrun_error = err;
    decoded_queue.push_back(r);
  endfunction

  // overrun: a single error result and the row starts over
  function automatic void queue_overrun();
    row_pos = 0;
    queue_result('0, '0, COUNT_NONE, 1'b1, 1'b0, 1'b1);
  endfunction

  // expand one accepted byte into the results it should cause
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    int unsigned n;
    int unsigned k;
    int unsigned take;
    bit          rend;
    // pass-through drops any run in progress
    if (mode_q == MODE_RAW) begin
      awaiting_value = 1'b0;
      literal_left   = 0;
      repeat_len     = 0;
      queue_result(b, '0, COUNT_ONE, 1'b1, close_byte(), 1'b0);
      return;
    end
    // literal data byte
    if (literal_left != 0) begin
      literal_left--;
      queue_result(b, '0, COUNT_ONE, 1'b1, close_byte(), 1'b0);
      return;
    end
    // value byte of a repeat run, two bytes per result
    if (awaiting_value) begin
      n = repeat_len;
      k = 0;
      awaiting_value = 1'b0;
      repeat_len     = 0;
      if (n == 0) begin
        queue_overrun();
        return;
      end
      while (n != 0 && k < 64) begin
        take = (n >= 2) ? 2 : 1;
        rend = close_byte();
        if (take == 2) rend |= close_byte();
        n -= take;
        queue_result(b, (take == 2) ? b : '0, (take == 2) ? COUNT_TWO : COUNT_ONE,
                     n == 0, rend, 1'b0);
        k++;
      end
      return;
    end
    // control byte
    if (b < CTRL_NOP) begin
      n = b + 1;
      if (row_pos + n > row_limit()) queue_overrun();
      else literal_left = n;
    end else if (b > CTRL_NOP) begin
      n = (b ^ BYTE_MASK) + 2;
      awaiting_value = 1'b1;
      // an overrunning repeat still eats its value byte, flagged by length zero
      repeat_len = (row_pos + n > row_limit()) ? 0 : n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver and monitor
  // ---------------------------------------------------------------------------

  // idle length for one item on either side; some draws skip idling altogether
  function automatic int unsigned draw_gap();
    if (quiet || $urandom_range(0, 99) < 35) return 0;
    return $urandom_range(0, 16);
  endfunction

  // sender: predicts on each accepted item, then offers the next one after its gap
  always @(posedge clk) begin : byte_driver
    bit fire;
    bit issue;
    if (!rst_n) begin
      in_valid <= 1'b0;
      armed = 1'b0;
      gap_left = 0;
    end else begin
      fire  = in_valid && in_ready;
      issue = 1'b0;
      if (fire) begin
        decode_byte(in_byte);
        items_accepted++;
      end
      if ((!in_valid || fire) && byte_stream.size() > 0) begin
        if (!armed) begin
          gap_left = draw_gap();
          armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!byte_stream[0].drain || decoded_queue.size() == 0) begin
          // drain items wait here until every owed result has come back
          in_byte <= byte_stream[0].value;
          issue = 1'b1;
          armed = 1'b0;
          void'(byte_stream.pop_front());
        end
      end
      // single update of valid per edge, so back-to-back items keep it high
      in_valid <= issue || (in_valid && !fire);
    end
  end

  // compare one accepted result against the oldest owed one
  task automatic check_result();
    brd_result_t got;
    brd_result_t want;
    got.byte_first    = out_byte_first;
    got.byte_second   = out_byte_second;
    got.byte_count    = out_byte_count;
    got.run_last      = out_run_last;
    got.row_end       = out_row_end;
    got.overrun_error = out_overrun_error;
    results_checked++;
    if (got.overrun_error === 1'b1) overruns_seen++;
    if (got.row_end === 1'b1) row_ends_seen++;
    if (decoded_queue.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("[%0t] result with nothing owed: first %h second %h count %0d", $realtime,
                 got.byte_first, got.byte_second, got.byte_count);
      return;
    end
    want = decoded_queue.pop_front();
    if (got.byte_first !== want.byte_first || got.byte_second !== want.byte_second ||
        got.byte_count !== want.byte_count || got.run_last !== want.run_last ||
        got.row_end !== want.row_end || got.overrun_error !== want.overrun_error) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("[%0t] result %0d mismatch", $realtime, results_checked);
        $display("  expected first %h second %h count %0d last %b row_end %b err %b",
                 want.byte_first, want.byte_second, want.byte_count, want.run_last,
                 want.row_end, want.overrun_error);
        $display("  actual   first %h second %h count %0d last %b row_end %b err %b",
                 got.byte_first, got.byte_second, got.byte_count, got.run_last,
                 got.row_end, got.overrun_error);
      end
    end
  endtask

  // receiver: checks each result, then stalls for a freshly drawn number of cycles
  always @(posedge clk) begin : result_monitor
    int unsigned next_stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        next_stall = draw_gap();
      end else if (stall_left > 0) begin
        next_stall = stall_left - 1;
      end else begin
        next_stall = 0;
      end
      stall_left = next_stall;
      out_ready <= (next_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void send(logic [BYTE_W-1:0] value, bit drain = 1'b0);
    stream_byte_t s;
    s.value = value;
    s.drain = drain;
    byte_stream.push_back(s);
  endfunction

  // run lengths lean short, with the odd long one up to the full 128
  function automatic int unsigned draw_run_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 4);
    if (pick < 95) return $urandom_range(5, 40);
    return $urandom_range(41, 128);
  endfunction

  // mostly well-formed runs with random content, plus nops and stray bytes
  task automatic add_random_traffic(input int unsigned budget);
    int unsigned pushed;
    int unsigned seq;
    int unsigned pick;
    int unsigned len;
    bit          drain;
    pushed = 0;
    seq = 0;
    while (pushed < budget) begin
      // at most one item per phase waits for the result side to empty first
      drain = (seq == 5);
      pick  = $urandom_range(0, 99);
      len   = draw_run_len();
      if (mode_q == MODE_RAW || pick >= 80) begin
        send(8'($urandom_range(0, 255)), drain);
        pushed++;
      end else if (pick < 40 && budget - pushed >= 2) begin
        // literal run: control byte then len data bytes, kept within the budget
        if (len > budget - pushed - 1) len = budget - pushed - 1;
        send(8'(len - 1), drain);
        repeat (len) send(8'($urandom_range(0, 255)));
        pushed += len + 1;
      end else if (pick < 75) begin
        // repeat run: control byte 257-len then the value
        if (len < 2) len = 2;
        send(8'(257 - len), drain);
        send(8'($urandom_range(0, 255)));
        pushed += 2;
      end else begin
        send(CTRL_NOP, drain);
        pushed++;
      end
      seq++;
    end
  endtask

  // block is idle once nothing is queued, in flight or owed, plus a settle margin
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_stream.size() > 0 || in_valid || decoded_queue.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_ROW_BYTES: row_bytes_q = value;
      CFG_COMP_MODE: mode_q = comp_mode_t'(value[0]);
      default: ;
    endcase
  endtask

  // new register setting between phases, only with the block idle
  task automatic configure(input int unsigned row, input comp_mode_t m, input bit calm);
    wait_idle();
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(row));
    write_reg(CFG_COMP_MODE, CFG_DATA_W'(m));
    cfg_wr_en <= 1'b0;
    quiet = calm;
    settings_used++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 40-byte rows, run-length mode
    send(8'h00); send(8'h11);                             // shortest literal
    send(8'h02); send(8'hFF); send(CTRL_NOP); send(8'h7F); // literal data at the extremes
    send(8'hFF); send(8'hAA);                             // shortest repeat, one result
    send(CTRL_NOP);                                       // nop control byte
    send(8'h81); send(8'h55);                             // repeat overrun, value still eaten
    send(8'h7F);                                          // literal overrun
    send(8'hDC); send(8'h00);                             // 37-byte repeat, odd tail
    send(8'h02); send(8'h01); send(8'h02); send(8'h03);   // literal landing on row end
    add_random_traffic(20);

    // row length above the maximum saturates; longest repeat gives 64 results
    configure(16383, MODE_BYTERUN, 1'b0);
    send(8'h81); send(8'h3C);
    add_random_traffic(30);

    configure(2, MODE_BYTERUN, 1'b0);
    add_random_traffic(30);
    send(8'h00);                                          // leave a literal open

    // zero and one both act as one-byte rows
    configure(0, MODE_BYTERUN, 1'b0);
    add_random_traffic(25);
    configure(1, MODE_BYTERUN, 1'b0);
    add_random_traffic(20);

    configure(8192, MODE_BYTERUN, 1'b1);
    add_random_traffic(30);
    configure(8193, MODE_BYTERUN, 1'b0);
    add_random_traffic(20);

    // odd row length splits two-byte results across the row end
    configure(7, MODE_BYTERUN, 1'b0);
    add_random_traffic(25);
    send(8'hF0);                                          // repeat left waiting for its value

    // pass-through clears the pending run
    configure(3, MODE_RAW, 1'b0);
    send(8'h00); send(8'hFF); send(CTRL_NOP);
    add_random_traffic(30);
    configure(0, MODE_RAW, 1'b0);
    add_random_traffic(15);

    configure(2 * $urandom_range(1, 100), MODE_BYTERUN, 1'b0);
    add_random_traffic(25);
    configure(40, MODE_BYTERUN, 1'b1);
    add_random_traffic(30);

    wait_idle();
    $display("covered %0d items under %0d register settings", items_accepted, settings_used);
    $display("%0d results checked: %0d overrun errors, %0d row ends, %0d failures",
             results_checked, overruns_seen, row_ends_seen, failures);
    if (failures == 0) begin
      $display("byterun_row_decoder_core regression: pass");
    end else begin
      $display("byterun_row_decoder_core regression: fail");
    end
    $finish;
  end

  // watchdog on a hung handshake
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycles, decoded_queue.size());
    $display("byterun_row_decoder_core regression: fail");
    $finish;
  end

endmodule
